[hw/rtl/fccw_pkg.sv]
// Shared types, constants and codes for the FAT cluster chain walker.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package fccw_pkg;

  // Depth of the visited-cluster list, also the hard cap on runs per chain.
  localparam int MAX_RUNS = 64;
  localparam int IDX_W    = $clog2(MAX_RUNS);
  localparam int CNT_W    = 7;
  localparam int OUT_W    = 96;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FAT_TYPE   = 2'd0,
    CFG_SPC        = 2'd1,
    CFG_DATA_START = 2'd2,
    CFG_MAX_RUNS   = 2'd3
  } cfg_index_t;

  localparam logic [1:0] FAT_T12 = 2'd0;
  localparam logic [1:0] FAT_T16 = 2'd1;
  localparam logic [1:0] FAT_T32 = 2'd2;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_REPLY = 1'b1;

  typedef enum logic [2:0] {
    RSN_RUNNING = 3'd0,
    RSN_END     = 3'd1,
    RSN_BAD     = 3'd2,
    RSN_FREE    = 3'd3,
    RSN_LOOP    = 3'd4,
    RSN_LIMIT   = 3'd5,
    RSN_INVALID = 3'd6,
    RSN_STRAY   = 3'd7
  } reason_t;

  typedef struct packed {
    logic [1:0]  fat_type;
    logic [7:0]  sectors_per_cluster;
    logic [31:0] data_start_sector;
    logic [6:0]  max_runs;
  } cfg_t;

  // One classified input transaction as it waits in the queue.
  typedef struct packed {
    logic        mode;
    logic [31:0] value;
    logic        below_two;
    logic        end_mark;
    logic        bad_mark;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } walk_state_t;

  function automatic logic is_end_mark(logic [1:0] fat_type, logic [31:0] v);
    logic r;
    if (fat_type == FAT_T12) r = (v >= 32'h0000_0FF8);
    else if (fat_type == FAT_T16) r = (v >= 32'h0000_FFF8);
    else r = (v >= 32'h0FFF_FFF8);
    return r;
  endfunction

  function automatic logic is_bad_mark(logic [1:0] fat_type, logic [31:0] v);
    logic r;
    if (fat_type == FAT_T12) r = (v == 32'h0000_0FF7);
    else if (fat_type == FAT_T16) r = (v == 32'h0000_FFF7);
    else r = (v == 32'h0FFF_FFF7);
    return r;
  endfunction

endpackage

[hw/rtl/fccw_front.sv]
// Front end of the chain walker: takes input transactions and classifies them.
// Depends on fccw_pkg; feeds fccw_queue.
`timescale 1ns / 1ps

module fccw_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,   // cluster_value
  input  logic                s_tuser,   // mode
  input  logic [1:0]          fat_type,
  input  logic                q_ready,
  output logic                q_push,
  output fccw_pkg::item_t     q_item
);
  import fccw_pkg::*;

  assign s_tready = q_ready;
  assign q_push   = s_tvalid && q_ready;

  // Marks set here. The user changes configuration only while idle; not enforced.
  always_comb begin
    q_item.mode      = s_tuser;
    q_item.value     = s_tdata;
    q_item.below_two = (s_tdata < 32'd2);
    q_item.end_mark  = is_end_mark(fat_type, s_tdata);
    q_item.bad_mark  = is_bad_mark(fat_type, s_tdata);
  end

endmodule

[hw/rtl/fccw_queue.sv]
// Two-entry queue of classified items between the front and back ends.
// Depends on fccw_pkg for the item type.
`timescale 1ns / 1ps

module fccw_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fccw_pkg::item_t  push_item,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output fccw_pkg::item_t  pop_item
);
  import fccw_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

[hw/rtl/fccw_back.sv]
// Back end of the chain walker: walk state, visited-cluster list and loop scan,
// sector arithmetic and the output register. Depends on fccw_pkg.
`timescale 1ns / 1ps

module fccw_back (
  input  logic                      clk,
  input  logic                      rst,
  input  fccw_pkg::cfg_t            cfg,
  input  logic                      q_valid,
  input  fccw_pkg::item_t           q_item,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [fccw_pkg::OUT_W-1:0] m_tdata
);
  import fccw_pkg::*;

  walk_state_t state, state_next;

  logic [31:0]      visited [MAX_RUNS];
  logic [CNT_W-1:0] run_count;
  logic             walk_busy;
  logic [31:0]      current_cluster;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_valid;
  logic [31:0]      rd_data;
  logic [39:0]      product;
  logic [39:0]      sector_sum;
  logic             res_run;
  logic             res_fin;
  reason_t          res_reason;

  // Output register.
  logic             out_valid;
  logic             o_run_valid;
  logic [39:0]      o_start;
  logic [7:0]       o_count;
  logic             o_req_valid;
  logic [31:0]      o_req_cluster;
  logic             o_finished;
  reason_t          o_reason;
  logic [CNT_W-1:0] o_runs;

  // Decision for the item at the head of the queue.
  logic             dec_clear;
  logic             dec_fin;
  logic             dec_scan;
  reason_t          dec_reason;
  logic [CNT_W-1:0] base_count;
  logic [CNT_W-1:0] limit;
  logic             scan_issue;
  logic             scan_hit;
  logic             out_free;

  assign limit    = (cfg.max_runs < CNT_W'(MAX_RUNS)) ? cfg.max_runs : CNT_W'(MAX_RUNS);
  assign out_free = !out_valid || m_tready;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  assign scan_issue = (state == ST_SCAN) && (scan_idx < run_count);
  assign scan_hit   = (state == ST_SCAN) && rd_valid && (rd_data == current_cluster);

  always_comb begin
    dec_clear  = (q_item.mode == MODE_START);
    dec_fin    = 1'b0;
    dec_scan   = 1'b0;
    dec_reason = RSN_RUNNING;
    base_count = dec_clear ? '0 : run_count;
    if (q_item.mode == MODE_START && (q_item.below_two || cfg.sectors_per_cluster == 8'd0)) begin
      dec_fin    = 1'b1;
      dec_reason = RSN_INVALID;
    end else if (q_item.mode == MODE_REPLY && !walk_busy) begin
      dec_reason = RSN_STRAY;
    end else if (q_item.mode == MODE_REPLY && q_item.below_two) begin
      dec_fin    = 1'b1;
      dec_reason = RSN_FREE;
    end else if (q_item.mode == MODE_REPLY && q_item.bad_mark) begin
      dec_fin    = 1'b1;
      dec_reason = RSN_BAD;
    end else if (q_item.end_mark) begin
      dec_fin    = 1'b1;
      dec_reason = RSN_END;
    end else if (base_count >= limit) begin
      dec_fin    = 1'b1;
      dec_reason = RSN_LIMIT;
    end else begin
      dec_scan   = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) state_next = dec_scan ? ST_SCAN : ST_EMIT;
      end
      ST_SCAN: begin
        if (scan_hit) state_next = ST_EMIT;
        else if (!scan_issue && !rd_valid) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Visited list: one write when a cluster joins the chain, one read per scan step.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      visited[run_count[IDX_W-1:0]] <= current_cluster;
    end
    if (scan_issue) begin
      rd_data <= visited[scan_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
      walk_busy <= 1'b0;
      rd_valid  <= 1'b0;
      scan_idx  <= '0;
    end else begin
      rd_valid <= scan_issue && !scan_hit;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (dec_clear) run_count <= '0;
            if (dec_clear || dec_fin) walk_busy <= 1'b0;
            scan_idx <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_hit) walk_busy <= 1'b0;
          else if (scan_issue) scan_idx <= scan_idx + CNT_W'(1);
        end
        ST_MUL: begin
          run_count <= run_count + CNT_W'(1);
          walk_busy <= 1'b1;
        end
        ST_ADD, ST_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result and arithmetic registers; the product of (cluster - 2) and the
  // cluster size is registered before the add of the data start sector.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      current_cluster <= q_item.value;
      res_run         <= dec_scan;
      res_fin         <= dec_fin;
      res_reason      <= dec_reason;
    end
    if (scan_hit) begin
      res_run    <= 1'b0;
      res_fin    <= 1'b1;
      res_reason <= RSN_LOOP;
    end
    if (state == ST_MUL) begin
      product <= {8'd0, current_cluster - 32'd2} * {32'd0, cfg.sectors_per_cluster};
    end
    if (state == ST_ADD) begin
      sector_sum <= {8'd0, cfg.data_start_sector} + product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      o_run_valid   <= res_run;
      o_start       <= res_run ? sector_sum : 40'd0;
      o_count       <= res_run ? cfg.sectors_per_cluster : 8'd0;
      o_req_valid   <= res_run;
      o_req_cluster <= res_run ? current_cluster : 32'd0;
      o_finished    <= res_fin;
      o_reason      <= res_reason;
      o_runs        <= run_count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, o_runs, o_reason, o_finished, o_req_cluster, o_req_valid,
                     o_count, o_start, o_run_valid};

endmodule

[hw/rtl/fat_cluster_chain_walker.sv]
// FAT cluster chain walker, top level. One result per input transaction.
// Items that end or are rejected at once go straight to the output register; a
// new run passes the loop scan (one visited-list read per cycle), then the
// multiply and add states, before the output register.
// One item is worked on at a time; a two-entry queue and the output register
// let both sides stall independently. Synchronous reset: walk idle, defaults.
`timescale 1ns / 1ps

module fat_cluster_chain_walker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // cluster_value
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  // run_valid, run_start_sector[40], run_sector_count[8], request_valid,
  // request_cluster[32], finished, end_reason[3], runs_so_far[7], zero pad[3]
  output logic [fccw_pkg::OUT_W-1:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fccw_pkg::*;

  cfg_t  cfg;
  logic  q_ready;
  logic  q_push;
  item_t q_in;
  logic  q_valid;
  logic  q_pop;
  item_t q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fat_type            <= FAT_T32;
      cfg.sectors_per_cluster <= 8'd1;
      cfg.data_start_sector   <= 32'd0;
      cfg.max_runs            <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FAT_TYPE:   cfg.fat_type            <= cfg_data[1:0];
        CFG_SPC:        cfg.sectors_per_cluster <= cfg_data[7:0];
        CFG_DATA_START: cfg.data_start_sector   <= cfg_data;
        CFG_MAX_RUNS:   cfg.max_runs            <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  fccw_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .fat_type (cfg.fat_type),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  fccw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_out)
  );

  fccw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[hw/rtl/fccw_checker.sv]
// Port-level checks for the chain walker, bound to the top level.
// Depends on fccw_pkg and fat_cluster_chain_walker.
`timescale 1ns / 1ps

module fccw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [fccw_pkg::OUT_W-1:0] m_tdata
);
  import fccw_pkg::*;

  logic       run_valid;
  logic       request_valid;
  logic       finished;
  logic [2:0] end_reason;
  logic [6:0] runs_so_far;

  assign run_valid     = m_tdata[0];
  assign request_valid = m_tdata[49];
  assign finished      = m_tdata[82];
  assign end_reason    = m_tdata[85:83];
  assign runs_so_far   = m_tdata[92:86];

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // A run always comes with its entry request and never ends the walk.
  a_run_request: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && run_valid |-> request_valid && !finished && end_reason == RSN_RUNNING)
    else $error("run without request or with an end");

  a_end_reason: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && finished |-> end_reason != RSN_RUNNING && end_reason != RSN_STRAY)
    else $error("finished with a wrong reason");

  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> runs_so_far <= 7'(MAX_RUNS))
    else $error("run count beyond the cap");

endmodule

bind fat_cluster_chain_walker fccw_checker u_fccw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
